>>> src/tgoa_pkg.sv
// Shared types and codes for the toroidal grid occupancy and adjacency block.
// Used by tgoa_ctrl, tgoa_dp and the top level; depends on nothing else.
`default_nettype none

package tgoa_pkg;

  // Fixed field widths of the external interface.
  localparam int FUNC_W    = 2;
  localparam int COORD_W   = 4;
  localparam int SIZE_W    = 5;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 16;
  localparam int OCC_W     = 13;
  localparam int PAIR_W    = 15;
  localparam int CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Read phases: each phase reads two counters from the memory.
  localparam logic [1:0] PH_CENTER_XP = 2'd0;
  localparam logic [1:0] PH_XM_YP     = 2'd1;
  localparam logic [1:0] PH_YM_ZP     = 2'd2;
  localparam logic [1:0] PH_ZM        = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       sweep;
    logic       rd_en;
    logic [1:0] phase;
    logic       finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/tgoa_ctrl.sv
// Controller state machine of the toroidal grid occupancy block.
// Depends on tgoa_pkg; drives the command struct of tgoa_dp.
`default_nettype none

module tgoa_ctrl import tgoa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] func,
  output logic                   in_stall,
  input  wire dp_stat_t          stat,
  output dp_cmd_t                cmd
);

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_CLR  = 8'b0000_0100,
    S_RD0  = 8'b0000_1000,
    S_RD1  = 8'b0001_0000,
    S_RD2  = 8'b0010_0000,
    S_RD3  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (func == FN_CLEAR) ? S_CLR : S_RD0;
        end
      end
      S_CLR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_FIN;
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.phase  = PH_CENTER_XP;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.phase  = PH_XM_YP;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.phase  = PH_YM_ZP;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.phase  = PH_ZM;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // An accepted item always starts either the read sequence or a clear sweep.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_RD0 || state == S_CLR))
    else $error("accepted item did not start processing");

  // The result stage is entered only from the last read, a clear sweep or itself.
  a_fin_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> $past(state == S_RD3 || state == S_CLR || state == S_FIN))
    else $error("result stage entered from an unexpected state");

  // Memory reads never coincide with a memory write.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (!cmd.sweep && !cmd.finish))
    else $error("read issued together with a write");

endmodule

`default_nettype wire

>>> src/tgoa_dp.sv
// Datapath of the toroidal grid occupancy block: size registers, counter
// memory, neighbour reads, running totals and the result register. Uses tgoa_pkg.
`default_nettype none

module tgoa_dp import tgoa_pkg::*; #(
  parameter int AXIS_MAX   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [COORD_W-1:0]   cell_x,
  input  wire logic [COORD_W-1:0]   cell_y,
  input  wire logic [COORD_W-1:0]   cell_z,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       status,
  output logic [CNT_OUT_W-1:0]      cell_count,
  output logic [OCC_W-1:0]          occupied_cells,
  output logic [PAIR_W-1:0]         adjacent_pairs
);

  localparam int DEPTH  = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_CAP = (AXIS_MAX > 31) ? SIZE_W'(31) : SIZE_W'(AXIS_MAX);
  localparam logic [SIZE_W-1:0] SIZE_RST = (AXIS_MAX < 16) ? SIZE_W'(AXIS_MAX) : SIZE_W'(16);
  localparam logic [ADDR_W-1:0] STRIDE   = ADDR_W'(AXIS_MAX);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Effective size: zero acts as one, anything above the axis length is capped.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_CAP) begin
      r = SIZE_CAP;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIZE_W-1:0] x,
                                                  input logic [SIZE_W-1:0] y,
                                                  input logic [SIZE_W-1:0] z);
    return (ADDR_W'(x) * STRIDE + ADDR_W'(y)) * STRIDE + ADDR_W'(z);
  endfunction

  function automatic logic [SIZE_W-1:0] wrap_inc(input logic [SIZE_W-1:0] c,
                                                 input logic [SIZE_W-1:0] s);
    return (c + SIZE_W'(1) == s) ? '0 : c + SIZE_W'(1);
  endfunction

  function automatic logic [SIZE_W-1:0] wrap_dec(input logic [SIZE_W-1:0] c,
                                                 input logic [SIZE_W-1:0] s);
    return (c == '0) ? s - SIZE_W'(1) : c - SIZE_W'(1);
  endfunction

  logic [SIZE_W-1:0]     size_x;
  logic [SIZE_W-1:0]     size_y;
  logic [SIZE_W-1:0]     size_z;
  logic [FUNC_W-1:0]     func_q;
  logic                  range_err;
  logic [SIZE_W-1:0]     x_q;
  logic [SIZE_W-1:0]     y_q;
  logic [SIZE_W-1:0]     z_q;
  logic                  in_range;
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_a;
  logic [COUNT_BITS-1:0] rd_b;
  logic [ADDR_W-1:0]     addr_a;
  logic [ADDR_W-1:0]     addr_b;
  logic [ADDR_W-1:0]     center_addr;
  logic [ADDR_W-1:0]     sweep_cnt;
  logic [COUNT_BITS-1:0] cnt_c;
  logic [4:0]            busy;
  logic [5:0]            busy_all;
  logic [5:0]            self_mask;
  logic [2:0]            nbr_cnt;
  logic [OCC_W-1:0]      occ;
  logic [OCC_W-1:0]      occ_next;
  logic [PAIR_W-1:0]     pair;
  logic [PAIR_W-1:0]     pair_next;
  logic [PAIR_W:0]       pair_sum;
  logic [STATUS_W-1:0]   res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic [COUNT_BITS+CNT_OUT_W-1:0] res_ext;
  logic                  fin_wr;
  logic [COUNT_BITS-1:0] fin_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // Size registers hold the effective sizes.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RST;
      size_y <= SIZE_RST;
      size_z <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x <= eff_size(cfg_data);
        CFG_SIZE_Y: size_y <= eff_size(cfg_data);
        CFG_SIZE_Z: size_z <= eff_size(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Item capture; out-of-range coordinates are replaced by zero so every
  // address stays inside the memory.
  assign in_range = ({1'b0, cell_x} < size_x) && ({1'b0, cell_y} < size_y) &&
                    ({1'b0, cell_z} < size_z);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= func;
      range_err <= !in_range;
      x_q       <= in_range ? {1'b0, cell_x} : '0;
      y_q       <= in_range ? {1'b0, cell_y} : '0;
      z_q       <= in_range ? {1'b0, cell_z} : '0;
    end
  end

  // Read addresses for each phase.
  assign center_addr = cell_addr(x_q, y_q, z_q);

  always_comb begin
    case (cmd.phase)
      PH_CENTER_XP: begin
        addr_a = center_addr;
        addr_b = cell_addr(wrap_inc(x_q, size_x), y_q, z_q);
      end
      PH_XM_YP: begin
        addr_a = cell_addr(wrap_dec(x_q, size_x), y_q, z_q);
        addr_b = cell_addr(x_q, wrap_inc(y_q, size_y), z_q);
      end
      PH_YM_ZP: begin
        addr_a = cell_addr(x_q, wrap_dec(y_q, size_y), z_q);
        addr_b = cell_addr(x_q, y_q, wrap_inc(z_q, size_z));
      end
      default: begin
        addr_a = cell_addr(x_q, y_q, wrap_dec(z_q, size_z));
        addr_b = center_addr;
      end
    endcase
  end

  // Sweep counter for the reset pass and for clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= (sweep_cnt == LAST_ADDR) ? '0 : sweep_cnt + ADDR_W'(1);
    end
  end

  // Counter memory: one write port, two registered read ports.
  assign mem_we    = cmd.sweep || (cmd.finish && fin_wr);
  assign mem_waddr = cmd.sweep ? sweep_cnt : center_addr;
  assign mem_wdata = cmd.sweep ? '0 : fin_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Collect the data of the previous phase.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      case (cmd.phase)
        PH_XM_YP: begin
          cnt_c   <= rd_a;
          busy[0] <= (rd_b != '0);
        end
        PH_YM_ZP: begin
          busy[1] <= (rd_a != '0);
          busy[2] <= (rd_b != '0);
        end
        PH_ZM: begin
          busy[3] <= (rd_a != '0);
          busy[4] <= (rd_b != '0);
        end
        default: begin
        end
      endcase
    end
  end

  // On an axis of size one both neighbours are the cell itself, which counts as empty.
  assign self_mask = {{2{size_z == SIZE_W'(1)}}, {2{size_y == SIZE_W'(1)}},
                      {2{size_x == SIZE_W'(1)}}};
  assign busy_all  = {(rd_a != '0), busy};
  assign nbr_cnt   = 3'($countones(busy_all & ~self_mask));
  assign pair_sum  = {1'b0, pair} + (PAIR_W + 1)'(nbr_cnt);

  // Result and state update of the finishing cycle.
  always_comb begin
    res_status = ST_OK;
    res_count  = '0;
    occ_next   = occ;
    pair_next  = pair;
    fin_wr     = 1'b0;
    fin_data   = cnt_c;
    case (func_q) inside
      FN_CLEAR: begin
        occ_next  = '0;
        pair_next = '0;
      end
      FN_ADD, FN_REMOVE: begin
        if (range_err) begin
          res_status = ST_RANGE;
        end else if (func_q == FN_ADD) begin
          if (cnt_c == COUNT_MAX) begin
            res_status = ST_FULL;
            res_count  = cnt_c;
          end else begin
            fin_wr    = 1'b1;
            fin_data  = cnt_c + COUNT_BITS'(1);
            res_count = cnt_c + COUNT_BITS'(1);
            if (cnt_c == '0) begin
              occ_next  = (occ == '1) ? occ : occ + OCC_W'(1);
              pair_next = pair_sum[PAIR_W] ? '1 : pair_sum[PAIR_W-1:0];
            end
          end
        end else begin
          if (cnt_c == '0) begin
            res_status = ST_EMPTY;
          end else begin
            fin_wr    = 1'b1;
            fin_data  = cnt_c - COUNT_BITS'(1);
            res_count = cnt_c - COUNT_BITS'(1);
            if (cnt_c == COUNT_BITS'(1)) begin
              occ_next  = (occ == '0) ? occ : occ - OCC_W'(1);
              pair_next = (pair < PAIR_W'(nbr_cnt)) ? '0 : pair - PAIR_W'(nbr_cnt);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_ext = {{CNT_OUT_W{1'b0}}, res_count};

  // Running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      pair <= '0;
    end else if (cmd.finish) begin
      occ  <= occ_next;
      pair <= pair_next;
    end
  end

  // Result register; it is refilled in the cycle it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= res_status;
      cell_count     <= res_ext[CNT_OUT_W-1:0];
      occupied_cells <= occ_next;
      adjacent_pairs <= pair_next;
    end
  end

  assign stat.sweep_last = (sweep_cnt == LAST_ADDR);
  assign stat.out_free   = !out_valid || !out_stall;

  // Each finished item leaves a result behind.
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item produced no result");

  // A sweep always ends with the counter back at the first address.
  a_sweep_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep && stat.sweep_last) |=> (sweep_cnt == '0))
    else $error("sweep counter did not return to zero");

  // Remove from an empty cell, or any item with an out-of-range index, reports a zero count.
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_EMPTY || status == ST_RANGE)) |-> (cell_count == '0))
    else $error("error result carries a nonzero count");

endmodule

`default_nettype wire

>>> src/toroidal_grid_occupancy_adjacency_top.sv
// Top level of the toroidal grid occupancy and adjacency block.
// Depends on tgoa_pkg, tgoa_ctrl and tgoa_dp.
//
//   Channel   Direction  Handshake          Payload
//   input     in         in_valid/in_stall  func, cell_x, cell_y, cell_z
//   result    out        out_valid/out_stall status, cell_count, occupied_cells,
//                                           adjacent_pairs
//   config    in         cfg_we             cfg_index, cfg_data
//
// Add and remove read the center counter and its six neighbours over two memory
// read ports in the read states S_RD0 to S_RD3, then the finishing step writes
// the counter and updates the totals.
// Clear walks the whole counter memory, one entry a cycle.
// After reset a pass clearing all AXIS_MAX**3 entries (4096 at the default) runs
// before the first item is accepted; configuration writes are taken throughout.
// A stalled result holds; a new item is accepted while it waits, and the next
// result is held back until the result register is free.
`default_nettype none

module toroidal_grid_occupancy_adjacency_top import tgoa_pkg::*; #(
  parameter int AXIS_MAX   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [COORD_W-1:0]   cell_x,
  input  wire logic [COORD_W-1:0]   cell_y,
  input  wire logic [COORD_W-1:0]   cell_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [CNT_OUT_W-1:0]      cell_count,
  output logic [OCC_W-1:0]          occupied_cells,
  output logic [PAIR_W-1:0]         adjacent_pairs
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  tgoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Counter memory, totals and result register.
  tgoa_dp #(
    .AXIS_MAX   (AXIS_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .cell_z         (cell_z),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .cell_count     (cell_count),
    .occupied_cells (occupied_cells),
    .adjacent_pairs (adjacent_pairs)
  );

endmodule

`default_nettype wire
